// ===== rtl/lbrps_pkg.sv =====
// Package for the log-binned radial power spectrum block.
// Holds the fixed grid and bin constants, the bin edge table and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbrps_pkg;

	localparam int GRID_SIZE  = 1024;
	localparam int NUM_BINS   = 20;
	localparam int BIN_W      = 5;
	localparam int IDX_W      = 10;
	localparam int R2_W       = 20;
	localparam int CNT_W      = 20;
	localparam int PWR_W      = 64;
	localparam int RSUM_W     = 40;
	localparam int RAD_W      = 18;
	localparam int SQRT_STEPS = 18;
	localparam int DIV_STEPS  = 64;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic              acc;
		logic [BIN_W-1:0]  bin;
		logic [PWR_W-1:0]  power;
		logic [RAD_W-1:0]  radius;
		logic              fin;
	} q_entry_t;

	typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_LOAD, B_DIV, B_OUT} back_state_t;

	// Lower squared-radius edge of each bin: smallest t with t^20 * 2^k >= 1024^(2k).
	function automatic logic [R2_W-1:0] edge_r2(input logic [BIN_W-1:0] k);
		logic [R2_W-1:0] e;
		case (k)
			5'd1:    e = 20'd2;
			5'd2:    e = 20'd4;
			5'd3:    e = 20'd8;
			5'd4:    e = 20'd14;
			5'd5:    e = 20'd27;
			5'd6:    e = 20'd52;
			5'd7:    e = 20'd101;
			5'd8:    e = 20'd195;
			5'd9:    e = 20'd375;
			5'd10:   e = 20'd725;
			5'd11:   e = 20'd1399;
			5'd12:   e = 20'd2703;
			5'd13:   e = 20'd5221;
			5'd14:   e = 20'd10086;
			5'd15:   e = 20'd19484;
			5'd16:   e = 20'd37641;
			5'd17:   e = 20'd72717;
			5'd18:   e = 20'd140480;
			5'd19:   e = 20'd271389;
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lbrps_front.sv =====
// Front end: accepts coefficients, folds the row, computes squared radius,
// bin, power and the Q8 radius by a bit-serial square root. Uses lbrps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbrps_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lbrps_pkg::IDX_W-1:0] row,
	input  wire logic [lbrps_pkg::IDX_W-1:0] col,
	input  wire logic signed [31:0]          re_part,
	input  wire logic signed [31:0]          im_part,
	input  wire logic                        final_item,
	output logic                             push,
	output lbrps_pkg::q_entry_t              push_data,
	input  wire logic                        q_full
);

	lbrps_pkg::front_state_t state_q, state_d;

	logic [lbrps_pkg::R2_W-1:0] r2_q;
	logic                       ok_q, fin_q;
	logic [31:0]                mag_re_q, mag_im_q;
	logic [63:0]                sq_re_q, sq_im_q;
	logic [35:0]                rem_q, root_q, bit_q;
	logic [4:0]                 step_q;

	logic                       accept;
	logic [lbrps_pkg::IDX_W-1:0] ia;
	logic [lbrps_pkg::R2_W-1:0] r2;
	logic                       ok;
	logic [35:0]                trial;
	logic                       take;
	logic                       sqrt_done;
	logic                       needed;
	logic [lbrps_pkg::BIN_W-1:0] bin;

	assign accept = in_valid && !in_stall;

	always_comb begin
		ia = (row > 10'd512) ? 10'(11'd1024 - {1'b0, row}) : row;
		r2 = 20'(ia * ia) + 20'(col * col);
		ok = (col <= 10'd512) && (r2 > 20'd1) && (r2 < 20'd524288);
	end

	assign trial     = root_q + bit_q;
	assign take      = rem_q >= trial;
	assign sqrt_done = step_q == 5'(lbrps_pkg::SQRT_STEPS - 1);
	assign needed    = ok_q || fin_q;

	always_comb begin
		bin = '0;
		for (int k = 1; k < lbrps_pkg::NUM_BINS; k++) begin
			if (r2_q >= lbrps_pkg::edge_r2(lbrps_pkg::BIN_W'(k))) begin
				bin = lbrps_pkg::BIN_W'(k);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbrps_pkg::F_IDLE: begin
				if (accept) state_d = lbrps_pkg::F_CALC;
			end
			lbrps_pkg::F_CALC: begin
				if (sqrt_done) state_d = lbrps_pkg::F_PUSH;
			end
			lbrps_pkg::F_PUSH: begin
				if (!needed || !q_full) state_d = lbrps_pkg::F_IDLE;
			end
			default: state_d = lbrps_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != lbrps_pkg::F_IDLE;
		push     = (state_q == lbrps_pkg::F_PUSH) && needed && !q_full;
		push_data.acc    = ok_q;
		push_data.bin    = bin;
		push_data.power  = sq_re_q + sq_im_q;
		push_data.radius = root_q[lbrps_pkg::RAD_W-1:0];
		push_data.fin    = fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbrps_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r2_q     <= r2;
			ok_q     <= ok;
			fin_q    <= final_item;
			mag_re_q <= re_part[31] ? (~re_part + 32'd1) : re_part;
			mag_im_q <= im_part[31] ? (~im_part + 32'd1) : im_part;
			rem_q    <= {r2[15:0], 16'd0} | {r2[19:16], 32'd0};
			root_q   <= '0;
			bit_q    <= 36'h4_0000_0000;
			step_q   <= '0;
		end else if (state_q == lbrps_pkg::F_CALC) begin
			if (step_q == 5'd0) begin
				sq_re_q <= 64'(mag_re_q) * 64'(mag_re_q);
				sq_im_q <= 64'(mag_im_q) * 64'(mag_im_q);
			end
			if (take) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q  <= bit_q >> 2;
			step_q <= step_q + 5'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbrps_fifo.sv =====
// Four-entry word queue between the front end and the accumulator.
// Uses lbrps_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module lbrps_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lbrps_pkg::q_entry_t push_data,
	output logic                     full,
	input  wire logic                pop,
	output lbrps_pkg::q_entry_t      head,
	output logic                     empty
);

	lbrps_pkg::q_entry_t mem_q [4];
	logic [1:0]          wr_q, rd_q;
	logic [2:0]          cnt_q;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== rtl/lbrps_back.sv =====
// Back end: per-bin accumulators, and on a final word the emission of every
// bin through a shared bit-serial divider. Uses lbrps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbrps_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire lbrps_pkg::q_entry_t head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [5:0]               bin_number,
	output logic [19:0]              bin_count,
	output logic [62:0]              mean_power,
	output logic [17:0]              mean_radius,
	output logic                     last_bin
);

	lbrps_pkg::back_state_t state_q, state_d;

	logic [lbrps_pkg::CNT_W-1:0]  cnt_q [lbrps_pkg::NUM_BINS];
	logic [lbrps_pkg::PWR_W-1:0]  pw_q  [lbrps_pkg::NUM_BINS];
	logic [lbrps_pkg::RSUM_W-1:0] rs_q  [lbrps_pkg::NUM_BINS];

	logic [lbrps_pkg::BIN_W-1:0] k_q;
	logic [5:0]                  dstep_q;
	logic [63:0]                 num_p_q, num_r_q;
	logic [20:0]                 rem_p_q, rem_r_q;
	logic [19:0]                 den_q;

	logic [20:0] sh_p, sh_r;
	logic        ge_p, ge_r;
	logic        is_last, out_take, div_done;
	logic [lbrps_pkg::CNT_W-1:0] hc;
	logic [lbrps_pkg::PWR_W:0]   psum;

	assign sh_p     = {rem_p_q[19:0], num_p_q[63]};
	assign sh_r     = {rem_r_q[19:0], num_r_q[63]};
	assign ge_p     = sh_p >= {1'b0, den_q};
	assign ge_r     = sh_r >= {1'b0, den_q};
	assign is_last  = k_q == lbrps_pkg::BIN_W'(lbrps_pkg::NUM_BINS - 1);
	assign out_take = out_valid && !out_stall;
	assign div_done = dstep_q == 6'(lbrps_pkg::DIV_STEPS - 1);
	assign hc       = cnt_q[head.bin];
	assign psum     = {1'b0, pw_q[head.bin]} + {1'b0, head.power};

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbrps_pkg::B_IDLE: begin
				if (!q_empty && head.fin) state_d = lbrps_pkg::B_LOAD;
			end
			lbrps_pkg::B_LOAD: state_d = lbrps_pkg::B_DIV;
			lbrps_pkg::B_DIV: begin
				if (div_done) state_d = lbrps_pkg::B_OUT;
			end
			lbrps_pkg::B_OUT: begin
				if (out_take) state_d = is_last ? lbrps_pkg::B_IDLE : lbrps_pkg::B_LOAD;
			end
			default: state_d = lbrps_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop         = (state_q == lbrps_pkg::B_IDLE) && !q_empty;
		out_valid   = state_q == lbrps_pkg::B_OUT;
		bin_number  = {1'b0, k_q};
		bin_count   = den_q;
		last_bin    = is_last;
		if (den_q == '0) begin
			mean_power  = '0;
			mean_radius = '0;
		end else begin
			mean_power  = num_p_q[63] ? {63{1'b1}} : num_p_q[62:0];
			mean_radius = (num_r_q[63:18] != '0) ? {18{1'b1}} : num_r_q[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbrps_pkg::B_IDLE;
			k_q     <= '0;
			for (int i = 0; i < lbrps_pkg::NUM_BINS; i++) begin
				cnt_q[i] <= '0;
				pw_q[i]  <= '0;
				rs_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				k_q <= '0;
				if (head.acc && hc != lbrps_pkg::COUNT_MAX) begin
					cnt_q[head.bin] <= hc + 20'd1;
					pw_q[head.bin]  <= psum[64] ? {64{1'b1}} : psum[63:0];
					rs_q[head.bin]  <= rs_q[head.bin] + 40'(head.radius);
				end
			end
			if (out_take) begin
				cnt_q[k_q] <= '0;
				pw_q[k_q]  <= '0;
				rs_q[k_q]  <= '0;
				k_q        <= k_q + lbrps_pkg::BIN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbrps_pkg::B_LOAD) begin
			num_p_q <= pw_q[k_q];
			num_r_q <= 64'(rs_q[k_q]);
			den_q   <= cnt_q[k_q];
			rem_p_q <= '0;
			rem_r_q <= '0;
			dstep_q <= '0;
		end else if (state_q == lbrps_pkg::B_DIV) begin
			num_p_q <= {num_p_q[62:0], ge_p};
			num_r_q <= {num_r_q[62:0], ge_r};
			rem_p_q <= ge_p ? sh_p - {1'b0, den_q} : sh_p;
			rem_r_q <= ge_r ? sh_r - {1'b0, den_q} : sh_r;
			dstep_q <= dstep_q + 6'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/log_binned_radial_power_spectrum.sv =====
// Top level of the log-binned radial power spectrum block.
// Instantiates lbrps_front, lbrps_fifo and lbrps_back; uses lbrps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one half-plane Fourier coefficient of a 1024 by 1024 grid per word and
// bins its power and Q8 radius into 20 logarithmic radius bins. The front end
// holds each coefficient through the bit-serial square root of the squared
// radius and the hand-off to the queue, and takes no new word until both are
// done. A word marked final_item is accumulated first, then all 20 bins are
// emitted in order, each after a serial division of its power and radius sums
// by its count; the front end keeps accepting words into its four-entry queue
// during emission.
module log_binned_radial_power_spectrum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [9:0]         row,
	input  wire logic [9:0]         col,
	input  wire logic signed [31:0] re_part,
	input  wire logic signed [31:0] im_part,
	input  wire logic               final_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [5:0]              bin_number,
	output logic [19:0]             bin_count,
	output logic [62:0]             mean_power,
	output logic [17:0]             mean_radius,
	output logic                    last_bin
);

	logic                push, pop, q_full, q_empty;
	lbrps_pkg::q_entry_t push_data, head;

	lbrps_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .row, .col, .re_part, .im_part,
		.final_item, .push, .push_data, .q_full
	);

	lbrps_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .full(q_full), .pop, .head,
		.empty(q_empty)
	);

	lbrps_back u_back (
		.clk, .arst_n, .q_empty, .head, .pop, .out_valid, .out_stall,
		.bin_number, .bin_count, .mean_power, .mean_radius, .last_bin
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for log_binned_radial_power_spectrum.
// Predicts the per-bin results from each accepted coefficient word and checks
// every output word. Depends on lbrps_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES  = 3000;

	typedef struct {
		logic [9:0]         row;
		logic [9:0]         col;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               fin;
	} coef_t;

	typedef struct {
		logic [5:0]  bin;
		logic [19:0] count;
		logic [62:0] power;
		logic [17:0] radius;
		logic        last;
	} bin_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [9:0]         row = '0;
	logic [9:0]         col = '0;
	logic signed [31:0] re_part = '0;
	logic signed [31:0] im_part = '0;
	logic               final_item = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [5:0]         bin_number;
	logic [19:0]        bin_count;
	logic [62:0]        mean_power;
	logic [17:0]        mean_radius;
	logic               last_bin;

	coef_t       coef_queue[$];
	bin_word_t   spectrum_queue[$];
	logic [19:0] edge_sq[lbrps_pkg::NUM_BINS];
	logic [19:0] acc_count[lbrps_pkg::NUM_BINS];
	logic [63:0] acc_power[lbrps_pkg::NUM_BINS];
	logic [63:0] acc_radius[lbrps_pkg::NUM_BINS];
	int          errors = 0;
	int          cycles = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_cnt = 0;
	bit          took = 1'b0;

	log_binned_radial_power_spectrum DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// True when t^NUM_BINS * 2^k >= GRID_SIZE^(2k), in exact wide arithmetic.
	function automatic bit edge_hit(int t, int k);
		logic [511:0] a;
		logic [511:0] b;
		a = 512'd1;
		for (int i = 0; i < lbrps_pkg::NUM_BINS; i++) a = a * 512'(t);
		a = a << k;
		b = 512'd1;
		for (int i = 0; i < 2 * k; i++) b = b * 512'(lbrps_pkg::GRID_SIZE);
		return a >= b;
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] t;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			t = res | (64'd1 << i);
			if (t * t <= v) res = t;
		end
		return res;
	endfunction

	function automatic logic [32:0] magnitude(logic [31:0] v);
		return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
	endfunction

	task automatic clear_bins();
		for (int k = 0; k < lbrps_pkg::NUM_BINS; k++) begin
			acc_count[k] = '0;
			acc_power[k] = '0;
			acc_radius[k] = '0;
		end
	endtask

	task automatic accumulate_coef(coef_t c);
		int unsigned n;
		int unsigned fr;
		int unsigned r2;
		int b;
		logic [64:0] pw;
		logic [64:0] sum;
		logic [32:0] mr;
		logic [32:0] mi;
		bin_word_t w;
		n = lbrps_pkg::GRID_SIZE;
		if (c.row < n && c.col <= n / 2) begin
			fr = (c.row > n / 2) ? n - c.row : c.row;
			r2 = fr * fr + c.col * c.col;
			if (r2 > 1 && 2 * r2 < n * n) begin
				b = 0;
				for (int k = 1; k < lbrps_pkg::NUM_BINS; k++) begin
					if (r2 >= edge_sq[k]) b = k;
				end
				if (acc_count[b] < lbrps_pkg::COUNT_MAX) begin
					mr = magnitude(c.re);
					mi = magnitude(c.im);
					pw = 65'(mr) * 65'(mr) + 65'(mi) * 65'(mi);
					sum = {1'b0, acc_power[b]} + pw;
					acc_power[b] = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
					acc_count[b]++;
					acc_radius[b] += isqrt(64'(r2) << 16);
				end
			end
		end
		if (c.fin) begin
			for (int k = 0; k < lbrps_pkg::NUM_BINS; k++) begin
				logic [63:0] mp;
				logic [63:0] mrad;
				mp = '0;
				mrad = '0;
				if (acc_count[k] != 0) begin
					mp = acc_power[k] / 64'(acc_count[k]);
					mrad = acc_radius[k] / 64'(acc_count[k]);
				end
				if (mp > 64'h7FFF_FFFF_FFFF_FFFF) mp = 64'h7FFF_FFFF_FFFF_FFFF;
				if (mrad > 64'h3FFFF) mrad = 64'h3FFFF;
				w.bin = 6'(k);
				w.count = acc_count[k];
				w.power = mp[62:0];
				w.radius = mrad[17:0];
				w.last = (k == lbrps_pkg::NUM_BINS - 1);
				spectrum_queue.push_back(w);
			end
			clear_bins();
		end
	endtask

	task automatic report(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		$display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
	endtask

	task automatic push_coef(int r, int c, logic [31:0] re, logic [31:0] im, bit fin);
		coef_t x;
		x.row = 10'(r);
		x.col = 10'(c);
		x.re = re;
		x.im = im;
		x.fin = fin;
		coef_queue.push_back(x);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 255)) - 32'd128;
			default: return $urandom;
		endcase
	endfunction

	// A frame of well-formed coefficients closed by a final word; now and then a
	// column past the half plane is mixed in.
	task automatic push_frame(int len);
		int c;
		for (int i = 0; i < len; i++) begin
			c = ($urandom_range(0, 9) == 0) ? $urandom_range(513, 1023)
			                                : $urandom_range(0, 512);
			if ($urandom_range(0, 5) == 0) c = $urandom_range(0, 4);
			push_coef($urandom_range(0, 1023), c, rand_value(), rand_value(), i == len - 1);
		end
	endtask

	task automatic wait_drained();
		while (coef_queue.size() != 0 || in_valid || spectrum_queue.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sender side: a word is taken on the edge where valid is high and stall is low.
	always @(posedge clk) begin
		coef_t c;
		took = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			c.row = row;
			c.col = col;
			c.re = re_part;
			c.im = im_part;
			c.fin = final_item;
			accumulate_coef(c);
			took = 1'b1;
		end
	end

	always @(negedge clk) begin
		coef_t c;
		if (arst_n && (!in_valid || took)) begin
			if (coef_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
				c = coef_queue.pop_front();
				row <= c.row;
				col <= c.col;
				re_part <= c.re;
				im_part <= c.im;
				final_item <= c.fin;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle);
		end
	end

	always @(posedge clk) begin
		bin_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (spectrum_queue.size() == 0) begin
				report("unexpected word, bin", 64'd0, 64'(bin_number));
			end else begin
				w = spectrum_queue.pop_front();
				if (bin_number !== w.bin)
					report("bin_number", 64'(w.bin), 64'(bin_number));
				if (bin_count !== w.count)
					report("bin_count", 64'(w.count), 64'(bin_count));
				if (mean_power !== w.power)
					report("mean_power", 64'(w.power), 64'(mean_power));
				if (mean_radius !== w.radius)
					report("mean_radius", 64'(w.radius), 64'(mean_radius));
				if (last_bin !== w.last)
					report("last_bin", 64'(w.last), 64'(last_bin));
			end
		end
	end

	initial begin
		int lo;
		int hi;
		int mid;
		int sent;
		edge_sq[0] = '0;
		for (int k = 1; k < lbrps_pkg::NUM_BINS; k++) begin
			lo = 1;
			hi = lbrps_pkg::GRID_SIZE * lbrps_pkg::GRID_SIZE;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (edge_hit(mid, k)) hi = mid;
				else lo = mid + 1;
			end
			edge_sq[k] = 20'(lo);
		end
		clear_bins();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: band limits, folding, column limit, top bin, power saturation.
		push_coef(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		push_coef(1, 0, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_coef(1, 1, 32'h0000_8000, 32'hFFFF_8000, 1'b0);
		push_coef(1023, 1, 32'h0001_0000, 32'h0, 1'b0);
		push_coef(2, 0, 32'h1234_5678, 32'hEDCB_A987, 1'b0);
		push_coef(513, 0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		push_coef(512, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		push_coef(511, 511, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_coef(511, 510, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_coef(510, 511, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_coef(3, 513, 32'h7FFF_FFFF, 32'h0, 1'b0);
		push_coef(5, 1023, 32'h7FFF_FFFF, 32'h0, 1'b0);
		push_coef(700, 300, 32'h0000_4000, 32'h0000_2000, 1'b0);
		push_coef(0, 0, 32'h1, 32'h1, 1'b1);
		push_coef(0, 0, 32'h0, 32'h0, 1'b1);
		push_coef(0, 512, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		push_coef(300, 200, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			tx_idle = (p == 0) ? 28 : (p == 1) ? 65 : 0;
			rx_idle = (p == 0) ? 65 : (p == 1) ? 28 : 0;
			if (p == 2) hold_req = 1'b1;
			sent = 0;
			while (sent < 64) begin
				mid = $urandom_range(1, 14);
				push_frame(mid);
				sent += mid;
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== log_binned_radial_power_spectrum.f =====
rtl/lbrps_pkg.sv
rtl/lbrps_front.sv
rtl/lbrps_fifo.sv
rtl/lbrps_back.sv
rtl/log_binned_radial_power_spectrum.sv
tb/testbench.sv
